// ===== hdl/mfat_pkg.sv =====
// Shared types and constants of the motor feedback frame angle tracker.
package mfat_pkg;

    localparam int FRAME_LEN_DEF = 8;    // bytes in a valid feedback frame
    localparam int STORE_BYTES   = 8;    // leading bytes of a frame that are kept
    localparam int STORE_IDX_W   = $clog2(STORE_BYTES);
    localparam int QUEUE_DEPTH   = 2;    // frame records between front and back

    localparam int ANGLE_W = 16;
    localparam int TURNS_W = 32;
    localparam int TOTAL_W = 48;
    localparam int ID_W    = 2;
    localparam int REV_SH  = 12;         // 4096 counts per turn
    localparam int DELTA_W = ANGLE_W + 1;

    // Input item kinds carried on tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    // Motor selector in frame byte 2
    localparam logic [7:0] MOTOR_ONE_BYTE = 8'h01;
    localparam logic [7:0] MOTOR_TWO_BYTE = 8'h02;

    // Motor identifiers on the result
    localparam logic [ID_W-1:0] MOTOR_ONE_ID = 2'd1;
    localparam logic [ID_W-1:0] MOTOR_TWO_ID = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ONE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TWO = 1'b1;

    // Unwrap thresholds on the signed angle jump
    localparam logic signed [DELTA_W-1:0] JUMP_POS = 17'sd2048;
    localparam logic signed [DELTA_W-1:0] JUMP_NEG = -17'sd2048;

    // One checked frame, handed from front to back
    typedef struct packed {
        logic               motor;   // 0 = motor one, 1 = motor two
        logic [ANGLE_W-1:0] angle;
    } t_frame_rec;

endpackage

// ===== hdl/mfat_front.sv =====
// Front end: counts and stores frame bytes, checks the frame on line idle.
module mfat_front #(
    parameter int FRAME_LEN = mfat_pkg::FRAME_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_op,
    input  logic [7:0]         i_byte,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output mfat_pkg::t_frame_rec o_rec
);
    import mfat_pkg::*;

    localparam int CNT_W = $clog2(FRAME_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_LEN   = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] CNT_STORE = CNT_W'(STORE_BYTES);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_bytes [STORE_BYTES];
    logic             accept;
    logic [7:0]       sum_hdr, sum_ang;
    logic             id_ok;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_op == OP_IDLE) begin
                n_count = '0;
            end else if (r_count < CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Keep only the leading bytes; later ones are counted but dropped
    always_ff @(posedge i_clk) begin
        if (accept && i_op == OP_BYTE && r_count < CNT_STORE) begin
            r_bytes[r_count[STORE_IDX_W-1:0]] <= i_byte;
        end
    end

    assign sum_hdr = r_bytes[0] + r_bytes[1] + r_bytes[2] + r_bytes[3];
    assign sum_ang = r_bytes[5] + r_bytes[6];
    assign id_ok   = (r_bytes[2] == MOTOR_ONE_BYTE) || (r_bytes[2] == MOTOR_TWO_BYTE);

    assign o_push = accept && (i_op == OP_IDLE) && (r_count == CNT_LEN)
                    && (sum_hdr == r_bytes[4]) && (sum_ang == r_bytes[7]) && id_ok;

    assign o_rec.motor = (r_bytes[2] == MOTOR_TWO_BYTE);
    assign o_rec.angle = {r_bytes[6], r_bytes[5]};

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("byte count beyond saturation");

    a_idle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_IDLE) |=> r_count == '0)
        else $error("idle did not clear byte count");

endmodule

// ===== hdl/mfat_queue.sv =====
// Short queue of checked frame records between front and back.
module mfat_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mfat_pkg::t_frame_rec i_rec,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output mfat_pkg::t_frame_rec o_rec
);
    import mfat_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    t_frame_rec       r_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == IDX_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == IDX_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("record pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("record popped from empty queue");

endmodule

// ===== hdl/mfat_back.sv =====
// Back end: per-motor unwrap of the angle and total angle arithmetic.
module mfat_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rec_valid,
    input  mfat_pkg::t_frame_rec           i_rec,
    output logic                           o_pop,
    input  logic [mfat_pkg::ANGLE_W-1:0]   i_offset_one,
    input  logic [mfat_pkg::ANGLE_W-1:0]   i_offset_two,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mfat_pkg::ID_W-1:0]      o_motor_id,
    output logic [mfat_pkg::ANGLE_W-1:0]   o_angle,
    output logic [mfat_pkg::TURNS_W-1:0]   o_turns,
    output logic [mfat_pkg::TOTAL_W-1:0]   o_total
);
    import mfat_pkg::*;

    // Per-motor tracking state
    logic [ANGLE_W-1:0] r_last [2];
    logic               r_cal  [2];
    logic [TURNS_W-1:0] r_turns [2];

    // Stage A: unwrap result
    logic                      r_a_valid;
    logic [ID_W-1:0]           r_a_id;
    logic [ANGLE_W-1:0]        r_a_angle;
    logic [TURNS_W-1:0]        r_a_turns;
    logic signed [DELTA_W-1:0] r_a_delta;

    // Stage B: output register
    logic               r_b_valid;
    logic [ID_W-1:0]    r_b_id;
    logic [ANGLE_W-1:0] r_b_angle;
    logic [TURNS_W-1:0] r_b_turns;
    logic [TOTAL_W-1:0] r_b_total;

    logic                      b_load;
    logic [ANGLE_W-1:0]        off, prev;
    logic signed [DELTA_W-1:0] jump;
    logic [TURNS_W-1:0]        n_turns;

    assign b_load = r_a_valid && (!r_b_valid || i_ready);
    assign o_pop  = i_rec_valid && (!r_a_valid || b_load);

    always_comb begin
        off  = i_rec.motor ? i_offset_two : i_offset_one;
        prev = r_cal[i_rec.motor] ? r_last[i_rec.motor] : off;
        jump = $signed({1'b0, i_rec.angle}) - $signed({1'b0, prev});
        n_turns = r_turns[i_rec.motor];
        if (jump > JUMP_POS) begin
            n_turns = r_turns[i_rec.motor] - 1'b1;
        end else if (jump < JUMP_NEG) begin
            n_turns = r_turns[i_rec.motor] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last[0]  <= '0;
            r_last[1]  <= '0;
            r_cal[0]   <= 1'b0;
            r_cal[1]   <= 1'b0;
            r_turns[0] <= '0;
            r_turns[1] <= '0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_last[i_rec.motor]  <= i_rec.angle;
                r_cal[i_rec.motor]   <= 1'b1;
                r_turns[i_rec.motor] <= n_turns;
                r_a_valid            <= 1'b1;
            end else if (b_load) begin
                r_a_valid <= 1'b0;
            end
            if (b_load) begin
                r_b_valid <= 1'b1;
            end else if (i_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_id    <= i_rec.motor ? MOTOR_TWO_ID : MOTOR_ONE_ID;
            r_a_angle <= i_rec.angle;
            r_a_turns <= n_turns;
            r_a_delta <= $signed({1'b0, i_rec.angle}) - $signed({1'b0, off});
        end
        if (b_load) begin
            r_b_id    <= r_a_id;
            r_b_angle <= r_a_angle;
            r_b_turns <= r_a_turns;
            r_b_total <= {{(TOTAL_W - TURNS_W - REV_SH){r_a_turns[TURNS_W-1]}},
                          r_a_turns, {REV_SH{1'b0}}}
                         + {{(TOTAL_W - DELTA_W){r_a_delta[DELTA_W-1]}}, r_a_delta};
        end
    end

    assign o_valid    = r_b_valid;
    assign o_motor_id = r_b_id;
    assign o_angle    = r_b_angle;
    assign o_turns    = r_b_turns;
    assign o_total    = r_b_total;

    a_cal_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_cal[$past(i_rec.motor)])
        else $error("motor not calibrated after a frame");

endmodule

// ===== hdl/motor_feedback_frame_angle_tracker_core.sv =====
// Top level of the motor feedback frame angle tracker.
//
//  channel   dir  handshake                      payload
//  s (input) in   i_s_tvalid / o_s_tready        tdata: rx_byte; tuser: operation
//  m (result)out  o_m_tvalid / i_m_tready        tdata: motor_id, angle, turn_count,
//                                                       total_angle
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One input transaction a cycle while the record queue has room; a full queue holds
// bytes and idles alike.
// A checked frame is written to the queue at the edge that accepts its idle
// transaction, then passes through the unwrap stage and the total-angle output
// register before it raises o_m_tvalid.
// Reset (synchronous, active low) clears byte count, queue, turn counts, calibration
// flags, last angles and offsets; the stored frame bytes are not cleared.
// A stalled result port fills the output register, the unwrap stage and then the
// queue before o_s_tready drops.
module motor_feedback_frame_angle_tracker_core #(
    parameter int FRAME_LEN = mfat_pkg::FRAME_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]                       i_s_tuser,   // [0] operation
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [1:0] motor_id, [17:2] angle, [49:18] turn_count, [97:50] total_angle,
    // [103:98] zero
    output logic [103:0]                     o_m_tdata,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mfat_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mfat_pkg::ANGLE_W-1:0]     i_cfg_data
);
    import mfat_pkg::*;

    localparam int PAY_W = ID_W + ANGLE_W + TURNS_W + TOTAL_W;
    localparam int PAD_W = 104 - PAY_W;

    logic [ANGLE_W-1:0] r_offset_one, r_offset_two;

    logic       q_full, q_valid, push, pop;
    t_frame_rec front_rec, q_rec;

    logic [ID_W-1:0]    res_id;
    logic [ANGLE_W-1:0] res_angle;
    logic [TURNS_W-1:0] res_turns;
    logic [TOTAL_W-1:0] res_total;

    // Offsets take any write; the user must change them only while the block is idle, as the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_one <= '0;
            r_offset_two <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OFFSET_ONE: r_offset_one <= i_cfg_data;
                CFG_OFFSET_TWO: r_offset_two <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: count, store and check; push a record per good frame
    mfat_front #(.FRAME_LEN(FRAME_LEN)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_op     (i_s_tuser[0]),
        .i_byte   (i_s_tdata),
        .i_q_full (q_full),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    // Decouple the front from result back-pressure
    mfat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    // Back: unwrap turns per motor, build the total angle
    mfat_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_valid  (q_valid),
        .i_rec        (q_rec),
        .o_pop        (pop),
        .i_offset_one (r_offset_one),
        .i_offset_two (r_offset_two),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_motor_id   (res_id),
        .o_angle      (res_angle),
        .o_turns      (res_turns),
        .o_total      (res_total)
    );

    // Pack result fields, lowest field first
    assign o_m_tdata = {{PAD_W{1'b0}}, res_total, res_turns, res_angle, res_id};

endmodule
